[rtl/pwlc_pkg.sv]
// ----------------------------------------------------------------------------
// pwlc_pkg
// types and constants shared by the window/level colouriser
// ----------------------------------------------------------------------------
package pwlc_pkg;

  // input beat
  typedef struct packed {
    logic [15:0] sample;
    logic [15:0] bias_sample;
    logic [7:0]  prior_red;
    logic [7:0]  prior_green;
    logic [7:0]  prior_blue;
    logic        frame_end;
  } in_t;

  // result beat
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end_out;
  } out_t;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [CFG_ADDR_W-1:0] CFG_DISP_MIN    = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DISP_MAX    = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_RED    = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_GREEN  = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_BLUE   = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLIP_MODE   = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_INVERT_MODE = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_BIAS_ENABLE = 4'd7;

  localparam int unsigned CFG_DATA_W = 16;

  // arithmetic constants
  localparam logic [13:0] BIAS_UNITY = 14'd10000;
  localparam logic [15:0] VAL_MAX    = 16'hFFFF;
  localparam logic [16:0] FRAC_ONE   = 17'h10000;
  localparam logic [7:0]  COL_MAX    = 8'hFF;

  // one quotient bit per divider stage
  localparam int unsigned DIV_STEPS = 16;

  // start to result strobe, in clock cycles
  localparam int unsigned LATENCY = 2 * DIV_STEPS + 7;

endpackage

[rtl/pixel_window_level_colorize.sv]
// ----------------------------------------------------------------------------
// pixel_window_level_colorize
// Window/level of one 16-bit microscope channel, added onto an RGB composite.
// A pixel is taken on every clock where start is high; busy never rises, as
// nothing downstream can stall. Each pixel gives exactly one result beat on
// out_strobe/out_data, in order. The pipe is made of two pipelined restoring
// dividers of 16 stages each (bias correction and window fraction) plus seven
// stages of multiply, compare and add around them. Configuration is taken on
// any cycle (cfg_ready stays high) and must only change while no pixel is in
// flight.
// ----------------------------------------------------------------------------
module pixel_window_level_colorize (
  input  logic                                clk,
  input  logic                                rst_n,
  // pixel input
  input  logic                                start,
  output logic                                busy,
  input  pwlc_pkg::in_t                       in_data,
  // result output
  output logic                                out_strobe,
  output pwlc_pkg::out_t                      out_data,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pwlc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pwlc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned N = pwlc_pkg::DIV_STEPS;

  // fields that ride along the whole pipe untouched
  typedef struct packed {
    logic [7:0] prior_red;
    logic [7:0] prior_green;
    logic [7:0] prior_blue;
    logic       frame_end;
  } side_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] disp_min_r;
  logic [15:0] disp_max_r;
  logic [7:0]  gain_red_r;
  logic [7:0]  gain_green_r;
  logic [7:0]  gain_blue_r;
  logic        clip_mode_r;
  logic        invert_mode_r;
  logic        bias_enable_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_min_r    <= 16'd0;
      disp_max_r    <= pwlc_pkg::VAL_MAX;
      gain_red_r    <= pwlc_pkg::COL_MAX;
      gain_green_r  <= pwlc_pkg::COL_MAX;
      gain_blue_r   <= pwlc_pkg::COL_MAX;
      clip_mode_r   <= 1'b1;
      invert_mode_r <= 1'b0;
      bias_enable_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        pwlc_pkg::CFG_DISP_MIN:    disp_min_r    <= cfg_data;
        pwlc_pkg::CFG_DISP_MAX:    disp_max_r    <= cfg_data;
        pwlc_pkg::CFG_GAIN_RED:    gain_red_r    <= cfg_data[7:0];
        pwlc_pkg::CFG_GAIN_GREEN:  gain_green_r  <= cfg_data[7:0];
        pwlc_pkg::CFG_GAIN_BLUE:   gain_blue_r   <= cfg_data[7:0];
        pwlc_pkg::CFG_CLIP_MODE:   clip_mode_r   <= cfg_data[0];
        pwlc_pkg::CFG_INVERT_MODE: invert_mode_r <= cfg_data[0];
        pwlc_pkg::CFG_BIAS_ENABLE: bias_enable_r <= cfg_data[0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input side: the pipe never stalls, so a pixel goes in on every start
  // --------------------------------------------------------------------------
  logic in_accept;
  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // --------------------------------------------------------------------------
  // stage a: sample times the unity bias (fits in 30 bits)
  // --------------------------------------------------------------------------
  logic        a_vld_r;
  logic [29:0] a_prod_r;
  logic [15:0] a_samp_r;
  logic [15:0] a_bias_r;
  side_t       a_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    a_prod_r              <= {14'd0, in_data.sample} * {16'd0, pwlc_pkg::BIAS_UNITY};
    a_samp_r              <= in_data.sample;
    a_bias_r              <= in_data.bias_sample;
    a_side_r.prior_red    <= in_data.prior_red;
    a_side_r.prior_green  <= in_data.prior_green;
    a_side_r.prior_blue   <= in_data.prior_blue;
    a_side_r.frame_end    <= in_data.frame_end;
  end

  // --------------------------------------------------------------------------
  // stage b: overflow check, then load the bias divider
  // the quotient fits 16 bits exactly when prod < bias * 2^16; the top bits
  // of prod are then already below the divisor and seed the remainder
  // --------------------------------------------------------------------------
  logic        b_sat_nxt;

  logic        d1_vld_r  [0:N];
  logic [15:0] d1_rem_r  [0:N];
  logic [15:0] d1_low_r  [0:N];
  logic [15:0] d1_den_r  [0:N];
  logic [15:0] d1_quo_r  [0:N];
  logic        d1_sat_r  [0:N];
  logic [15:0] d1_samp_r [0:N];
  side_t       d1_side_r [0:N];

  always_comb begin
    b_sat_nxt = (a_bias_r == 16'd0) ||
                ({2'b00, a_prod_r} >= {a_bias_r, 16'd0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r[0] <= 1'b0;
    end else begin
      d1_vld_r[0] <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_rem_r[0]  <= b_sat_nxt ? 16'd0 : {2'b00, a_prod_r[29:16]};
    d1_low_r[0]  <= a_prod_r[15:0];
    d1_den_r[0]  <= a_bias_r;
    d1_quo_r[0]  <= 16'd0;
    d1_sat_r[0]  <= b_sat_nxt;
    d1_samp_r[0] <= a_samp_r;
    d1_side_r[0] <= a_side_r;
  end

  // bias divider: one restoring step per stage
  for (genvar k = 0; k < N; k++) begin : g_div1
    logic [16:0] sh;
    logic        ge;
    logic [16:0] diff;

    always_comb begin
      sh   = {d1_rem_r[k], d1_low_r[k][15]};
      diff = sh - {1'b0, d1_den_r[k]};
      ge   = (sh >= {1'b0, d1_den_r[k]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_vld_r[k+1] <= 1'b0;
      end else begin
        d1_vld_r[k+1] <= d1_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      d1_rem_r[k+1]  <= ge ? diff[15:0] : sh[15:0];
      d1_low_r[k+1]  <= {d1_low_r[k][14:0], 1'b0};
      d1_den_r[k+1]  <= d1_den_r[k];
      d1_quo_r[k+1]  <= {d1_quo_r[k][14:0], ge};
      d1_sat_r[k+1]  <= d1_sat_r[k];
      d1_samp_r[k+1] <= d1_samp_r[k];
      d1_side_r[k+1] <= d1_side_r[k];
    end
  end

  // --------------------------------------------------------------------------
  // stage c: pick the corrected value, then the non-clipping rule
  // --------------------------------------------------------------------------
  logic [15:0] c_val_nxt;
  logic [15:0] c_v_nxt;
  logic        c_vld_r;
  logic [15:0] c_v_r;
  side_t       c_side_r;

  always_comb begin
    if (!bias_enable_r) begin
      c_val_nxt = d1_samp_r[N];
    end else if (d1_sat_r[N]) begin
      c_val_nxt = pwlc_pkg::VAL_MAX;
    end else begin
      c_val_nxt = d1_quo_r[N];
    end
    // above the window with clipping off falls back to the minimum
    if (!clip_mode_r && (c_val_nxt > disp_max_r)) begin
      c_v_nxt = disp_min_r;
    end else begin
      c_v_nxt = c_val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= d1_vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    c_v_r    <= c_v_nxt;
    c_side_r <= d1_side_r[N];
  end

  // --------------------------------------------------------------------------
  // stage d: classify against the window and load the fraction divider
  // inside the window v - min < max - min, so the quotient fits 16 bits
  // --------------------------------------------------------------------------
  logic        d_zero_nxt;
  logic        d_one_nxt;

  logic        d2_vld_r  [0:N];
  logic [15:0] d2_rem_r  [0:N];
  logic [15:0] d2_den_r  [0:N];
  logic [15:0] d2_quo_r  [0:N];
  logic        d2_zero_r [0:N];
  logic        d2_one_r  [0:N];
  side_t       d2_side_r [0:N];

  always_comb begin
    d_zero_nxt = (c_v_r <= disp_min_r);
    d_one_nxt  = !d_zero_nxt && ((disp_max_r <= disp_min_r) || (c_v_r >= disp_max_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_vld_r[0] <= 1'b0;
    end else begin
      d2_vld_r[0] <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    d2_rem_r[0]  <= (d_zero_nxt || d_one_nxt) ? 16'd0 : (c_v_r - disp_min_r);
    d2_den_r[0]  <= disp_max_r - disp_min_r;
    d2_quo_r[0]  <= 16'd0;
    d2_zero_r[0] <= d_zero_nxt;
    d2_one_r[0]  <= d_one_nxt;
    d2_side_r[0] <= c_side_r;
  end

  // fraction divider: zeros shifted in below the remainder
  for (genvar k = 0; k < N; k++) begin : g_div2
    logic [16:0] sh;
    logic        ge;
    logic [16:0] diff;

    always_comb begin
      sh   = {d2_rem_r[k], 1'b0};
      diff = sh - {1'b0, d2_den_r[k]};
      ge   = (sh >= {1'b0, d2_den_r[k]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d2_vld_r[k+1] <= 1'b0;
      end else begin
        d2_vld_r[k+1] <= d2_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      d2_rem_r[k+1]  <= ge ? diff[15:0] : sh[15:0];
      d2_den_r[k+1]  <= d2_den_r[k];
      d2_quo_r[k+1]  <= {d2_quo_r[k][14:0], ge};
      d2_zero_r[k+1] <= d2_zero_r[k];
      d2_one_r[k+1]  <= d2_one_r[k];
      d2_side_r[k+1] <= d2_side_r[k];
    end
  end

  // --------------------------------------------------------------------------
  // stage f: intensity fraction in q1.16, 0 .. 1.0 inclusive, then inversion
  // --------------------------------------------------------------------------
  logic [16:0] f_raw_nxt;
  logic [16:0] f_nxt;
  logic        f_vld_r;
  logic [16:0] f_r;
  side_t       f_side_r;

  always_comb begin
    if (d2_zero_r[N]) begin
      f_raw_nxt = 17'd0;
    end else if (d2_one_r[N]) begin
      f_raw_nxt = pwlc_pkg::FRAC_ONE;
    end else begin
      f_raw_nxt = {1'b0, d2_quo_r[N]};
    end
    f_nxt = invert_mode_r ? (pwlc_pkg::FRAC_ONE - f_raw_nxt) : f_raw_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= d2_vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    f_r      <= f_nxt;
    f_side_r <= d2_side_r[N];
  end

  // --------------------------------------------------------------------------
  // stage m: fraction times each gain; at most 255 after dropping 16 bits
  // --------------------------------------------------------------------------
  logic [24:0] m_red_prod;
  logic [24:0] m_green_prod;
  logic [24:0] m_blue_prod;
  logic        m_vld_r;
  logic [7:0]  m_red_r;
  logic [7:0]  m_green_r;
  logic [7:0]  m_blue_r;
  side_t       m_side_r;

  always_comb begin
    m_red_prod   = {8'd0, f_r} * {17'd0, gain_red_r};
    m_green_prod = {8'd0, f_r} * {17'd0, gain_green_r};
    m_blue_prod  = {8'd0, f_r} * {17'd0, gain_blue_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m_red_r   <= m_red_prod[23:16];
    m_green_r <= m_green_prod[23:16];
    m_blue_r  <= m_blue_prod[23:16];
    m_side_r  <= f_side_r;
  end

  // --------------------------------------------------------------------------
  // stage o: add onto the prior composite, saturating at 255
  // --------------------------------------------------------------------------
  logic [8:0]     o_red_sum;
  logic [8:0]     o_green_sum;
  logic [8:0]     o_blue_sum;
  logic           out_vld_r;
  pwlc_pkg::out_t out_data_r;

  always_comb begin
    o_red_sum   = {1'b0, m_side_r.prior_red}   + {1'b0, m_red_r};
    o_green_sum = {1'b0, m_side_r.prior_green} + {1'b0, m_green_r};
    o_blue_sum  = {1'b0, m_side_r.prior_blue}  + {1'b0, m_blue_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.red           <= o_red_sum[8]   ? pwlc_pkg::COL_MAX : o_red_sum[7:0];
    out_data_r.green         <= o_green_sum[8] ? pwlc_pkg::COL_MAX : o_green_sum[7:0];
    out_data_r.blue          <= o_blue_sum[8]  ? pwlc_pkg::COL_MAX : o_blue_sum[7:0];
    out_data_r.frame_end_out <= m_side_r.frame_end;
  end

  // one result beat per pixel, held for a single cycle
  assign out_strobe = out_vld_r;
  assign out_data   = out_data_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // every accepted pixel yields its beat after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##(pwlc_pkg::LATENCY) out_strobe)
    else $error("result beat missing after pipeline latency");

  // a non-saturated bias division leaves a proper remainder
  a_div1_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (d1_vld_r[N] && !d1_sat_r[N]) |-> (d1_rem_r[N] < d1_den_r[N]))
    else $error("bias divider remainder out of range");

  // inside the window the fraction divider leaves a proper remainder
  a_div2_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (d2_vld_r[N] && !d2_zero_r[N] && !d2_one_r[N]) |-> (d2_rem_r[N] < d2_den_r[N]))
    else $error("fraction divider remainder out of range");

  // fraction never exceeds one
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    f_vld_r |-> (f_r <= pwlc_pkg::FRAC_ONE))
    else $error("intensity fraction above one");
`endif

endmodule

[tb/pixel_colour_checker.sv]
// ----------------------------------------------------------------------------
// pixel_colour_checker
// Watches the pixel, result and register channels of the window/level
// colouriser, predicts each blended pixel from its own copy of the registers
// and compares every result beat, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module pixel_colour_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  pwlc_pkg::in_t                   in_data,
  input  logic                            out_strobe,
  input  pwlc_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pwlc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pwlc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              beats_checked
);

  // register copy
  logic [15:0] win_min, win_max;
  logic [7:0]  gain_r, gain_g, gain_b;
  logic        clip_on, invert_on, bias_on;

  pwlc_pkg::out_t expected_pixels[$];

  function automatic logic [7:0] blend(logic [7:0] prior, logic [16:0] frac, logic [7:0] gain);
    int unsigned sum;
    sum = 32'(prior) + ((32'(frac) * 32'(gain)) >> 16);
    return (sum > 255) ? 8'hFF : sum[7:0];
  endfunction

  function automatic pwlc_pkg::out_t predict_pixel(pwlc_pkg::in_t px);
    logic [15:0] lvl;
    logic [16:0] frac;
    int unsigned quot;
    pwlc_pkg::out_t res;
    lvl = px.sample;
    if (bias_on) begin
      if (px.bias_sample == 16'd0) begin
        lvl = 16'hFFFF;
      end else begin
        quot = (32'(px.sample) * 32'd10000) / 32'(px.bias_sample);
        lvl  = (quot > 32'd65535) ? 16'hFFFF : quot[15:0];
      end
    end
    // non-clipping mode folds above-window values back to the floor
    if (!clip_on && lvl > win_max) lvl = win_min;
    if (lvl <= win_min) begin
      frac = 17'd0;
    end else if (win_max <= win_min || lvl >= win_max) begin
      frac = 17'h10000;
    end else begin
      frac = 17'((32'(lvl - win_min) << 16) / 32'(win_max - win_min));
    end
    if (invert_on) frac = 17'h10000 - frac;
    res.red           = blend(px.prior_red,   frac, gain_r);
    res.green         = blend(px.prior_green, frac, gain_g);
    res.blue          = blend(px.prior_blue,  frac, gain_b);
    res.frame_end_out = px.frame_end;
    return res;
  endfunction

  always @(posedge clk) begin
    pwlc_pkg::out_t want;
    if (!rst_n) begin
      win_min       = 16'd0;
      win_max       = 16'hFFFF;
      gain_r        = 8'hFF;
      gain_g        = 8'hFF;
      gain_b        = 8'hFF;
      clip_on       = 1'b1;
      invert_on     = 1'b0;
      bias_on       = 1'b0;
      fail_count    = 0;
      pending       = 0;
      beats_checked = 0;
    end else begin
      if (out_strobe) begin
        beats_checked++;
        if (expected_pixels.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result beat: r=%0d g=%0d b=%0d fe=%0b", $time,
                   out_data.red, out_data.green, out_data.blue, out_data.frame_end_out);
        end else begin
          want = expected_pixels.pop_front();
          if (out_data !== want) begin
            fail_count++;
            $display("%0t mismatch: expected r=%0d g=%0d b=%0d fe=%0b,",
                     $time, want.red, want.green, want.blue, want.frame_end_out,
                     " got r=%0d g=%0d b=%0d fe=%0b",
                     out_data.red, out_data.green, out_data.blue, out_data.frame_end_out);
          end
        end
      end
      if (start && !busy) expected_pixels.push_back(predict_pixel(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          pwlc_pkg::CFG_DISP_MIN:    win_min   = cfg_data;
          pwlc_pkg::CFG_DISP_MAX:    win_max   = cfg_data;
          pwlc_pkg::CFG_GAIN_RED:    gain_r    = cfg_data[7:0];
          pwlc_pkg::CFG_GAIN_GREEN:  gain_g    = cfg_data[7:0];
          pwlc_pkg::CFG_GAIN_BLUE:   gain_b    = cfg_data[7:0];
          pwlc_pkg::CFG_CLIP_MODE:   clip_on   = cfg_data[0];
          pwlc_pkg::CFG_INVERT_MODE: invert_on = cfg_data[0];
          pwlc_pkg::CFG_BIAS_ENABLE: bias_on   = cfg_data[0];
          default: ;
        endcase
      end
      pending = expected_pixels.size();
    end
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the window/level colouriser with a directed set of corner pixels and
// then randomised phases, each under a fresh register setting and one of three
// levels of input idling. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned PHASE_BEATS    = 95;
  localparam int unsigned ADDR_W         = pwlc_pkg::CFG_ADDR_W;
  localparam int unsigned DATA_W         = pwlc_pkg::CFG_DATA_W;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  pwlc_pkg::in_t     in_data;
  logic              out_strobe;
  pwlc_pkg::out_t    out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_addr;
  logic [DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int beats_checked;

  int          pixels_sent;
  int          settings_used;
  int unsigned quiet_cycles;

  // window currently programmed, only used to aim the stimulus
  logic [15:0] cur_min, cur_max;

  pixel_window_level_colorize dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  pixel_colour_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_strobe    (out_strobe),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .beats_checked (beats_checked)
  );

  // free-running clock, period 20
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog: any cycle with no beat on any channel counts towards the limit
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog expired, %0d beats still awaited", $time, pending);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic pwlc_pkg::in_t mk_px(logic [15:0] s, logic [15:0] b, logic [7:0] pr,
                                          logic [7:0] pg, logic [7:0] pb, logic fe);
    pwlc_pkg::in_t p;
    p.sample      = s;
    p.bias_sample = b;
    p.prior_red   = pr;
    p.prior_green = pg;
    p.prior_blue  = pb;
    p.frame_end   = fe;
    return p;
  endfunction

  // window bounds lean towards the edges of the range
  function automatic logic [15:0] pick_bound();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // random pixel, mostly aimed inside the programmed window
  function automatic pwlc_pkg::in_t make_pixel();
    pwlc_pkg::in_t p;
    logic [15:0]   lo, hi;
    lo = (cur_min < cur_max) ? cur_min : cur_max;
    hi = (cur_min < cur_max) ? cur_max : cur_min;
    p = mk_px(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              $urandom_range(0, 15) == 0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: p.sample = 16'($urandom_range(hi, lo));
      5, 6:          ; // full range
      default: begin
        case ($urandom_range(0, 5))
          0: p.sample = 16'd0;
          1: p.sample = 16'hFFFF;
          2: p.sample = cur_min;
          3: p.sample = cur_max;
          4: p.sample = cur_min + 16'd1;
          default: p.sample = cur_max - 16'd1;
        endcase
      end
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: p.bias_sample = 16'($urandom_range(20000, 5000));
      7:                   p.bias_sample = 16'd0;
      8:                   p.bias_sample = 16'($urandom_range(100, 1));
      default:             ; // full range
    endcase
    // push the red and green sums into saturation now and then, and start blue from zero
    if ($urandom_range(0, 4) == 0) p.prior_red = 8'hFF;
    if ($urandom_range(0, 4) == 0) p.prior_green = 8'hFF;
    if ($urandom_range(0, 4) == 0) p.prior_blue = 8'd0;
    return p;
  endfunction

  // one pixel beat, after a random number of idle cycles; starts and ends at
  // a falling edge, so start is only ever assigned once per step
  task automatic send_px(input pwlc_pkg::in_t px, input int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= pwlc_pkg::in_t'({$urandom, $urandom});
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= px;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
  endtask

  // nothing may be in flight while the registers change
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // writes every register; with junk set the unused upper data bits are
  // random, which the block has to ignore
  task automatic apply_window(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [7:0] gr, input logic [7:0] gg,
                              input logic [7:0] gb, input logic clip,
                              input logic inv, input logic bias, input logic junk);
    logic [15:0] upper;
    wait_drained();
    upper = junk ? 16'($urandom) : 16'd0;
    write_reg(pwlc_pkg::CFG_DISP_MIN,    lo);
    write_reg(pwlc_pkg::CFG_DISP_MAX,    hi);
    write_reg(pwlc_pkg::CFG_GAIN_RED,    {upper[15:8], gr});
    write_reg(pwlc_pkg::CFG_GAIN_GREEN,  {upper[7:0], gg});
    write_reg(pwlc_pkg::CFG_GAIN_BLUE,   {upper[15:8], gb});
    write_reg(pwlc_pkg::CFG_CLIP_MODE,   {upper[15:1], clip});
    write_reg(pwlc_pkg::CFG_INVERT_MODE, {upper[14:0], inv});
    write_reg(pwlc_pkg::CFG_BIAS_ENABLE, {upper[15:1], bias});
    // an index past the last register must change nothing
    if (junk) write_reg(pwlc_pkg::CFG_BIAS_ENABLE + ADDR_W'($urandom_range(8, 1)),
                        16'($urandom));
    cfg_valid <= 1'b0;
    cur_min = lo;
    cur_max = hi;
    settings_used++;
  endtask

  initial begin
    int unsigned idle_pct;
    logic [15:0] lo, hi, tmp;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_addr    = '0;
    cfg_data    = '0;
    pixels_sent   = 0;
    settings_used = 0;
    cur_min     = 16'd0;
    cur_max     = 16'hFFFF;

    // synchronous reset, released at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed: reset setting, full window, full gains
    send_px(mk_px(16'd0,     16'd0, 8'd0,   8'd0,   8'd0,   1'b0), 0);
    send_px(mk_px(16'hFFFF,  16'd0, 8'd0,   8'd0,   8'd0,   1'b0), 0);
    send_px(mk_px(16'd32768, 16'd0, 8'd200, 8'd10,  8'd128, 1'b0), 0);
    send_px(mk_px(16'hFFFF,  16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), 0);

    // ---- directed: bias correction with the non-clipping fold
    apply_window(16'd1000, 16'd3000, 8'hFF, 8'd128, 8'd1, 1'b0, 1'b0, 1'b1, 1'b0);
    send_px(mk_px(16'd1234,  16'd0,     8'd5,  8'd6,  8'd7,  1'b0), 0); // zero bias
    send_px(mk_px(16'd2000,  16'd10000, 8'd0,  8'd0,  8'd0,  1'b0), 0); // unity bias
    send_px(mk_px(16'd5000,  16'd10000, 8'd0,  8'd0,  8'd0,  1'b0), 0); // above window
    send_px(mk_px(16'd1000,  16'd10000, 8'd9,  8'd9,  8'd9,  1'b0), 0); // at minimum
    send_px(mk_px(16'd3000,  16'd10000, 8'd1,  8'd2,  8'd3,  1'b1), 0); // at maximum
    send_px(mk_px(16'hFFFF,  16'd1,     8'd0,  8'd0,  8'd0,  1'b0), 0); // quotient saturates
    send_px(mk_px(16'd1500,  16'd5000,  8'd0,  8'd0,  8'd0,  1'b0), 0);
    send_px(mk_px(16'd2999,  16'd10000, 8'hFF, 8'd0,  8'd0,  1'b0), 0);

    // ---- directed: empty window, inverted, clipping
    apply_window(16'd5000, 16'd5000, 8'd0, 8'hFF, 8'd77, 1'b1, 1'b1, 1'b0, 1'b0);
    send_px(mk_px(16'd5001, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0), 0);
    send_px(mk_px(16'd5000, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0), 0);
    send_px(mk_px(16'd4999, 16'd0, 8'd100, 8'd200, 8'd250, 1'b0), 0);
    send_px(mk_px(16'hFFFF, 16'd0, 8'd0, 8'd0, 8'd0, 1'b1), 0);

    // ---- directed: reversed window
    apply_window(16'd40000, 16'd100, 8'd200, 8'd50, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0);
    send_px(mk_px(16'd40001, 16'd0, 8'd0,  8'd0,  8'd0,  1'b0), 0);
    send_px(mk_px(16'd200,   16'd0, 8'd60, 8'd60, 8'd60, 1'b0), 0);
    send_px(mk_px(16'hFFFF,  16'd0, 8'd0,  8'd0,  8'd0,  1'b0), 0);

    // ---- random phases, each with its own setting and one of three idling levels
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 88;
        default: idle_pct = 11;
      endcase
      if (ph == 0) begin
        apply_window(16'd0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0);
      end else if (ph == 1) begin
        apply_window(16'hFFFF, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b1);
      end else begin
        lo = pick_bound();
        hi = pick_bound();
        // mostly a proper window, sometimes reversed or empty
        if ($urandom_range(0, 9) < 7 && lo > hi) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
        if ($urandom_range(0, 9) == 0) hi = lo;
        apply_window(lo, hi, pick_gain(), pick_gain(), pick_gain(), 1'($urandom),
                     1'($urandom), 1'($urandom), 1'($urandom));
      end
      for (int n = 0; n < PHASE_BEATS; n++) send_px(make_pixel(), idle_pct);
    end

    // ---- drain, then give the pipeline time to show any stray beat
    wait_drained();
    repeat (pwlc_pkg::LATENCY + 8) @(negedge clk);

    $display("run covered %0d pixels under %0d register settings, %0d result beats checked",
             pixels_sent, settings_used, beats_checked);
    $display("idling levels used on the pixel input: none, 11 and 88 percent");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pwlc_pkg.sv
rtl/pixel_window_level_colorize.sv
tb/pixel_colour_checker.sv
tb/testbench.sv
